FILE: src/sorted_timer_queue_unit_macros.svh
// Assertion macros for the sorted timer queue unit
`ifndef SORTED_TIMER_QUEUE_UNIT_MACROS_SVH
`define SORTED_TIMER_QUEUE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define STQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define STQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define STQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define STQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and codes of the sorted timer queue unit.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int unsigned NumTimersDefault = 16;
    localparam int unsigned MaxReports       = 16;
    localparam logic [9:0]  TpsReset         = 10'd18;
    localparam logic [31:0] Sat32            = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        REQ_SET_TICKS = 3'd0,
        REQ_SET_SEC   = 3'd1,
        REQ_SET_MS    = 3'd2,
        REQ_RESET_SEC = 3'd3,
        REQ_CLEAR     = 3'd4,
        REQ_TICK      = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        EV_SET_DONE   = 3'd0,
        EV_NOT_ACTIVE = 3'd1,
        EV_CLEARED    = 3'd2,
        EV_FIRED      = 3'd3,
        EV_TICK_NONE  = 3'd4,
        EV_RESET_DONE = 3'd5
    } t_event;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request word
        logic scale;     // register delay * tps
        logic div;       // register ms quotient
        logic sum;       // register saturated expiry
        logic write;     // write entry and order
        logic retime;    // write expiry and order only
        logic disarm;    // drop armed bit of request timer
        logic tick;      // advance time
        logic scan_clr;  // start best search
        logic scan_step; // compare one timer
        logic fire;      // disarm best
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic armed;     // request timer armed
        logic idx_ok;    // request index in range
        logic found;     // search found a candidate
    } t_stat;

endpackage

FILE: src/stq_datapath.sv
// ----------------------------------------------------------------------------
// stq_datapath
// Timer table, time counter, delay scaling and expiry search unit.
// ----------------------------------------------------------------------------
`include "sorted_timer_queue_unit_macros.svh"
module stq_datapath #(
    parameter int unsigned NUM_TIMERS = stq_pkg::NumTimersDefault,
    parameter int unsigned IW = $clog2(NUM_TIMERS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stq_pkg::t_cmd     i_cmd,
    output stq_pkg::t_stat    o_stat,
    input  logic [9:0]        i_tps,
    input  logic [2:0]        i_req_type,
    input  logic [3:0]        i_timer_index,
    input  logic [15:0]       i_delay_amount,
    input  logic [7:0]        i_handler_code,
    input  logic [15:0]       i_user_argument,
    input  logic [IW-1:0]     i_scan_idx,
    output logic [2:0]        o_req,
    output logic [3:0]        o_req_idx,
    output logic [IW-1:0]     o_best,
    output logic [7:0]        o_best_handler,
    output logic [15:0]       o_best_argument
);
    import stq_pkg::*;

    logic [2:0]  r_req;
    logic [3:0]  r_idx;
    logic [15:0] r_delay, r_arg;
    logic [7:0]  r_hnd;
    logic [25:0] r_scaled;
    logic [25:0] r_ticks;
    logic [31:0] r_exp_new;
    logic [31:0] r_now, r_order;
    logic [NUM_TIMERS-1:0] r_armed;
    logic [31:0] r_exp [NUM_TIMERS];
    logic [31:0] r_ord [NUM_TIMERS];
    logic [7:0]  r_h   [NUM_TIMERS];
    logic [15:0] r_a   [NUM_TIMERS];
    logic        r_found;
    logic [IW-1:0] r_best;
    logic [31:0] r_best_exp, r_best_ord;
    logic [IW-1:0] w_ridx;
    logic        w_ok;
    logic [32:0] w_sum;
    logic [31:0] w_ord_n;
    logic [35:0] w_q;
    logic [25:0] w_prod;
    logic        w_better;

    assign w_ok   = ({28'd0, r_idx} < 32'(NUM_TIMERS));
    assign w_ridx = IW'(r_idx);
    assign w_sum  = {1'b0, r_now} + {7'd0, r_ticks};
    assign w_ord_n = (r_order == Sat32) ? r_order : r_order + 32'd1;
    assign w_prod = 26'(r_delay) * 26'(i_tps);
    // divide by 1000: multiply by ceil(2^36/1000) reciprocal, exact below 2^26
    assign w_q = 36'((62'(r_scaled) * 62'(68719477)) >> 36);

    assign w_better = r_armed[i_scan_idx] && (r_exp[i_scan_idx] <= r_now) &&
        (!r_found || r_exp[i_scan_idx] < r_best_exp ||
         (r_exp[i_scan_idx] == r_best_exp && r_ord[i_scan_idx] < r_best_ord));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now   <= '0;
            r_order <= '0;
            r_armed <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_req   <= i_req_type;
                r_idx   <= i_timer_index;
                r_delay <= i_delay_amount;
                r_hnd   <= i_handler_code;
                r_arg   <= i_user_argument;
            end
            if (i_cmd.scale) begin
                r_scaled <= w_prod;
                r_ticks  <= (r_req == REQ_SET_TICKS) ? {10'd0, r_delay} : w_prod;
            end
            if (i_cmd.div)  r_ticks <= w_q[25:0];
            if (i_cmd.sum)  r_exp_new <= w_sum[32] ? Sat32 : w_sum[31:0];
            if (i_cmd.write || i_cmd.retime) begin
                r_exp[w_ridx] <= r_exp_new;
                r_ord[w_ridx] <= w_ord_n;
                r_order       <= w_ord_n;
            end
            if (i_cmd.write) begin
                r_h[w_ridx]     <= r_hnd;
                r_a[w_ridx]     <= r_arg;
                r_armed[w_ridx] <= 1'b1;
            end
            if (i_cmd.disarm) r_armed[w_ridx] <= 1'b0;
            if (i_cmd.tick && r_now != Sat32) r_now <= r_now + 32'd1;
            if (i_cmd.scan_clr) r_found <= 1'b0;
            if (i_cmd.scan_step && w_better) begin
                r_found    <= 1'b1;
                r_best     <= i_scan_idx;
                r_best_exp <= r_exp[i_scan_idx];
                r_best_ord <= r_ord[i_scan_idx];
            end
            if (i_cmd.fire) r_armed[r_best] <= 1'b0;
        end
    end

    assign o_stat.armed  = w_ok && r_armed[w_ridx];
    assign o_stat.idx_ok = w_ok;
    assign o_stat.found  = r_found;
    assign o_req         = r_req;
    assign o_req_idx     = r_idx;
    assign o_best        = r_best;
    assign o_best_handler  = r_h[r_best];
    assign o_best_argument = r_a[r_best];

    `STQ_ASSERT_NXT(a_fire_disarms, i_clk, i_rst_n, i_cmd.fire, !r_armed[$past(r_best)])
    `STQ_ASSERT_NXT(a_time_mono, i_clk, i_rst_n, 1'b1, r_now >= $past(r_now))
    `STQ_ASSERT_NXT(a_write_arms, i_clk, i_rst_n, i_cmd.write, r_armed[$past(w_ridx)])
endmodule

FILE: src/stq_ctrl.sv
// ----------------------------------------------------------------------------
// stq_ctrl
// Request sequencer: scaling, table update, tick scan and report output.
// ----------------------------------------------------------------------------
`include "sorted_timer_queue_unit_macros.svh"
module stq_ctrl #(
    parameter int unsigned NUM_TIMERS = stq_pkg::NumTimersDefault,
    parameter int unsigned IW = $clog2(NUM_TIMERS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output stq_pkg::t_cmd     o_cmd,
    input  stq_pkg::t_stat    i_stat,
    input  logic [2:0]        i_req,
    input  logic [3:0]        i_req_idx,
    input  logic [IW-1:0]     i_best,
    input  logic [7:0]        i_best_handler,
    input  logic [15:0]       i_best_argument,
    output logic [IW-1:0]     o_scan_idx,
    output logic [2:0]        o_event_kind,
    output logic [3:0]        o_event_timer,
    output logic [7:0]        o_event_handler,
    output logic [15:0]       o_event_argument,
    output logic              o_last_report
);
    import stq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SCALE, S_DIV, S_SUM, S_WRITE,
        S_SCAN, S_FIRE, S_OUT
    } t_state;

    localparam logic [IW-1:0] LastIdx = IW'(NUM_TIMERS - 1);

    t_state      r_state;
    logic [IW-1:0] r_scan;
    logic [4:0]  r_nrep;
    logic        r_valid, r_more;
    logic [2:0]  r_kind;
    logic [3:0]  r_tmr;
    logic [7:0]  r_hnd;
    logic [15:0] r_arg;
    logic        r_last;
    logic [3:0]  r_p_tmr;
    logic [7:0]  r_p_hnd;
    logic [15:0] r_p_arg;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:   o_cmd.load = i_valid;
            S_SCALE:  o_cmd.scale = 1'b1;
            S_DIV:    o_cmd.div = (i_req == REQ_SET_MS);
            S_SUM:    o_cmd.sum = 1'b1;
            S_WRITE: begin
                o_cmd.write  = (i_req != REQ_RESET_SEC);
                o_cmd.retime = (i_req == REQ_RESET_SEC);
            end
            S_DECODE: begin
                o_cmd.tick     = (i_req == REQ_TICK);
                o_cmd.scan_clr = (i_req == REQ_TICK);
                o_cmd.disarm   = (i_req == REQ_CLEAR) && i_stat.idx_ok;
            end
            S_SCAN:   o_cmd.scan_step = 1'b1;
            S_FIRE: begin
                o_cmd.fire     = i_stat.found && (r_nrep != 5'(MaxReports));
                o_cmd.scan_clr = 1'b1;
            end
            default:  o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_scan  <= '0;
            r_nrep  <= '0;
            r_more  <= 1'b0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid) r_state <= S_DECODE;
                S_DECODE: begin
                    r_hnd <= '0;
                    r_arg <= '0;
                    r_tmr <= i_req_idx;
                    r_last <= 1'b1;
                    r_nrep <= '0;
                    r_scan <= '0;
                    r_more <= 1'b0;
                    if (i_req == REQ_TICK) begin
                        r_state <= S_SCAN;
                    end else if (i_req > REQ_TICK || !i_stat.idx_ok) begin
                        r_kind <= EV_NOT_ACTIVE;
                        r_state <= S_OUT;
                    end else if (i_req == REQ_CLEAR) begin
                        r_kind <= i_stat.armed ? EV_CLEARED : EV_NOT_ACTIVE;
                        r_state <= S_OUT;
                    end else if (i_req == REQ_RESET_SEC && !i_stat.armed) begin
                        r_kind <= EV_NOT_ACTIVE;
                        r_state <= S_OUT;
                    end else begin
                        r_kind <= (i_req == REQ_RESET_SEC) ? EV_RESET_DONE : EV_SET_DONE;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: r_state <= S_DIV;
                S_DIV:   r_state <= S_SUM;
                S_SUM:   r_state <= S_WRITE;
                S_WRITE: r_state <= S_OUT;
                S_SCAN: begin
                    r_scan <= r_scan + 1'b1;
                    if (r_scan == LastIdx) r_state <= S_FIRE;
                end
                S_FIRE: begin
                    r_scan <= '0;
                    if (o_cmd.fire) begin
                        // hold the new timer; send the one held before, if any, as not last
                        r_p_tmr <= 4'(i_best);
                        r_p_hnd <= i_best_handler;
                        r_p_arg <= i_best_argument;
                        r_nrep  <= r_nrep + 5'd1;
                        r_more  <= 1'b1;
                        r_kind  <= EV_FIRED;
                        r_tmr   <= r_p_tmr;
                        r_hnd   <= r_p_hnd;
                        r_arg   <= r_p_arg;
                        r_last  <= 1'b0;
                        r_state <= (r_nrep == '0) ? S_SCAN : S_OUT;
                    end else if (r_nrep != '0) begin
                        // nothing more to fire: the held timer is the final word
                        r_kind  <= EV_FIRED;
                        r_tmr   <= r_p_tmr;
                        r_hnd   <= r_p_hnd;
                        r_arg   <= r_p_arg;
                        r_last  <= 1'b1;
                        r_more  <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_kind <= EV_TICK_NONE;
                        r_tmr  <= '0;
                        r_last <= 1'b1;
                        r_more <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold the word until it is taken
                    if (!r_valid) r_valid <= 1'b1;
                    else if (i_ready) r_state <= r_more ? S_SCAN : S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_valid;
    assign o_scan_idx       = r_scan;
    assign o_event_kind     = r_kind;
    assign o_event_timer    = r_tmr;
    assign o_event_handler  = r_hnd;
    assign o_event_argument = r_arg;
    assign o_last_report    = r_last;

    `STQ_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == S_IDLE)
    `STQ_ASSERT_IMP(a_nrep_max, i_clk, i_rst_n, 1'b1, r_nrep <= 5'(MaxReports))
    `STQ_ASSERT_NXT(a_fire_out, i_clk, i_rst_n, o_cmd.fire, r_state == S_OUT || r_state == S_SCAN)
endmodule

FILE: src/sorted_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_timer_queue_unit
// One-shot timer table with sorted expiry reporting and APB scale register.
// ----------------------------------------------------------------------------
// One request word is taken at a time, and the next is taken only after the
// last report of the previous word has been accepted. After acceptance, a set
// or reset request passes decode, scale, divide, sum, write and output before
// o_valid rises; a clear, an invalid request or a reset of an unarmed timer
// passes decode and output. A tick runs search passes (one timer compared a
// cycle, then a fire step); with k fired timers it needs k+1 passes, each fired
// timer being held until the following pass tells whether it is the final one.
// Every report word is held in the output stage, longer while i_ready is low.
// Fired reports are delivered one word each; the final one carries
// o_last_report.
module sorted_timer_queue_unit #(
    parameter int unsigned NUM_TIMERS = stq_pkg::NumTimersDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [3:0]  i_timer_index,
    input  logic [15:0] i_delay_amount,
    input  logic [7:0]  i_handler_code,
    input  logic [15:0] i_user_argument,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_kind,
    output logic [3:0]  o_event_timer,
    output logic [7:0]  o_event_handler,
    output logic [15:0] o_event_argument,
    output logic        o_last_report
);
    import stq_pkg::*;

    localparam int unsigned IW = $clog2(NUM_TIMERS);

    logic [9:0]    r_tps;
    t_cmd          w_cmd;
    t_stat         w_stat;
    logic [2:0]    w_req;
    logic [3:0]    w_req_idx;
    logic [IW-1:0] w_best, w_scan;
    logic [7:0]    w_bh;
    logic [15:0]   w_ba;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TpsReset;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_tps <= pwdata[9:0];
        end
    end
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {22'd0, r_tps} : 32'd0;

    stq_ctrl #(.NUM_TIMERS(NUM_TIMERS), .IW(IW)) u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .o_valid, .i_ready,
        .o_cmd(w_cmd), .i_stat(w_stat), .i_req(w_req), .i_req_idx(w_req_idx),
        .i_best(w_best), .i_best_handler(w_bh), .i_best_argument(w_ba),
        .o_scan_idx(w_scan), .o_event_kind, .o_event_timer, .o_event_handler,
        .o_event_argument, .o_last_report
    );

    stq_datapath #(.NUM_TIMERS(NUM_TIMERS), .IW(IW)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_stat(w_stat), .i_tps(r_tps),
        .i_req_type, .i_timer_index, .i_delay_amount, .i_handler_code,
        .i_user_argument, .i_scan_idx(w_scan), .o_req(w_req), .o_req_idx(w_req_idx),
        .o_best(w_best), .o_best_handler(w_bh), .o_best_argument(w_ba)
    );
endmodule

FILE: verif/stq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_checker
// Watches the request and report channels of the timer queue, keeps its own
// timer table, and compares every report word against the predicted queue.
// ----------------------------------------------------------------------------
module stq_checker
    import stq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [9:0]  i_cfg_tps,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [3:0]  i_timer_index,
    input  logic [15:0] i_delay_amount,
    input  logic [7:0]  i_handler_code,
    input  logic [15:0] i_user_argument,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [2:0]  o_event_kind,
    input  logic [3:0]  o_event_timer,
    input  logic [7:0]  o_event_handler,
    input  logic [15:0] o_event_argument,
    input  logic        o_last_report,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_fired_seen
);

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  tmr;
        logic [7:0]  hnd;
        logic [15:0] arg;
        logic        last;
    } t_report;

    t_report     report_q[$];
    logic [9:0]  tps;
    logic [31:0] now_tick;
    logic [31:0] order_count;
    logic        armed[16];
    logic [31:0] expiry[16];
    logic [31:0] order[16];
    logic [7:0]  handler[16];
    logic [15:0] argument[16];

    assign o_pending = report_q.size();

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [63:0] b);
        logic [63:0] s;
        s = {32'd0, a} + b;
        return (s > 64'hFFFF_FFFF) ? Sat32 : s[31:0];
    endfunction

    function automatic logic [31:0] take_order();
        if (order_count != Sat32) order_count++;
        return order_count;
    endfunction

    function automatic void push(logic [2:0] k, logic [3:0] t, logic [7:0] h,
                                 logic [15:0] a, logic l);
        t_report r;
        r.kind = k; r.tmr = t; r.hnd = h; r.arg = a; r.last = l;
        report_q.push_back(r);
    endfunction

    task automatic predict_request(logic [2:0] req, logic [3:0] idx,
                                   logic [15:0] dly, logic [7:0] hnd,
                                   logic [15:0] arg);
        int          best;
        int          n;
        logic [63:0] ticks;
        n = 0;
        if (req == REQ_TICK) begin
            if (now_tick != Sat32) now_tick++;
            while (n < MaxReports) begin
                best = -1;
                for (int i = 0; i < 16; i++) begin
                    if (!armed[i] || expiry[i] > now_tick) continue;
                    if (best < 0 || expiry[i] < expiry[best] ||
                        (expiry[i] == expiry[best] && order[i] < order[best]))
                        best = i;
                end
                if (best < 0) break;
                armed[best] = 1'b0;
                if (n > 0) report_q[report_q.size()-1].last = 1'b0;
                push(EV_FIRED, best[3:0], handler[best], argument[best], 1'b1);
                n++;
            end
            if (n == 0) push(EV_TICK_NONE, 4'd0, 8'd0, 16'd0, 1'b1);
        end else if (req > REQ_TICK) begin
            push(EV_NOT_ACTIVE, idx, 8'd0, 16'd0, 1'b1);
        end else if (req <= REQ_SET_MS) begin
            ticks = {48'd0, dly};
            if (req == REQ_SET_SEC) ticks = ticks * tps;
            else if (req == REQ_SET_MS) ticks = (ticks * tps) / 1000;
            expiry[idx]   = sat_sum(now_tick, ticks);
            order[idx]    = take_order();
            handler[idx]  = hnd;
            argument[idx] = arg;
            armed[idx]    = 1'b1;
            push(EV_SET_DONE, idx, 8'd0, 16'd0, 1'b1);
        end else if (req == REQ_RESET_SEC) begin
            if (armed[idx]) begin
                expiry[idx] = sat_sum(now_tick, {48'd0, dly} * tps);
                order[idx]  = take_order();
                push(EV_RESET_DONE, idx, 8'd0, 16'd0, 1'b1);
            end else begin
                push(EV_NOT_ACTIVE, idx, 8'd0, 16'd0, 1'b1);
            end
        end else begin
            push(armed[idx] ? EV_CLEARED : EV_NOT_ACTIVE, idx, 8'd0, 16'd0, 1'b1);
            armed[idx] = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (!i_rst_n) begin
            tps           = TpsReset;
            now_tick      = '0;
            order_count   = '0;
            o_fail_count <= 0;
            o_fired_seen <= 0;
            for (int i = 0; i < 16; i++) armed[i] = 1'b0;
            report_q.delete();
        end else begin
            if (i_cfg_we) tps = i_cfg_tps;
            if (o_valid && i_ready) begin
                got = {o_event_kind, o_event_timer, o_event_handler,
                       o_event_argument, o_last_report};
                if (o_event_kind == EV_FIRED) o_fired_seen <= o_fired_seen + 1;
                if (report_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected report word %h", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = report_q.pop_front();
                    if (got != want) begin
                        if (o_fail_count < 10)
                            $display({"ERROR: report kind/tmr/hnd/arg/last ",
                                      "exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d"},
                                     want.kind, want.tmr, want.hnd, want.arg, want.last,
                                     got.kind, got.tmr, got.hnd, got.arg, got.last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            // predict after popping, so a report cannot match its own request
            if (i_valid && o_ready)
                predict_request(i_req_type, i_timer_index, i_delay_amount,
                                i_handler_code, i_user_argument);
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Random and directed test of the sorted timer queue: drives requests and
// ticks with random idling, rescales ticks per second between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import stq_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_req_type = '0;
    logic [3:0]  i_timer_index = '0;
    logic [15:0] i_delay_amount = '0;
    logic [7:0]  i_handler_code = '0;
    logic [15:0] i_user_argument = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_event_kind;
    logic [3:0]  o_event_timer;
    logic [7:0]  o_event_handler;
    logic [15:0] o_event_argument;
    logic        o_last_report;
    int          fail_count, pending, fired_seen;
    int          word_count;
    bit          calm;
    bit          long_hold;

    localparam logic [1:0] AddrTps = 2'd0;

    always #2 i_clk = ~i_clk;

    sorted_timer_queue_unit dut (.*);

    stq_checker u_checker (
        .i_clk, .i_rst_n,
        .i_cfg_we(psel && penable && pwrite && pready && paddr == AddrTps),
        .i_cfg_tps(pwdata[9:0]),
        .i_valid, .o_ready, .i_req_type, .i_timer_index, .i_delay_amount,
        .i_handler_code, .i_user_argument, .o_valid, .i_ready,
        .o_event_kind, .o_event_timer, .o_event_handler, .o_event_argument,
        .o_last_report,
        .o_fail_count(fail_count), .o_pending(pending), .o_fired_seen(fired_seen)
    );

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off, none when calm
    initial begin
        @(negedge i_clk);
        forever begin
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                long_hold = 1'b0;
            end else if (!calm && $urandom_range(3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    task automatic write_tps(logic [9:0] val);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= AddrTps; pwdata <= {22'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send(logic [2:0] req, logic [3:0] idx, logic [15:0] dly,
                        logic [7:0] hnd, logic [15:0] arg);
        if (!calm && $urandom_range(3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_valid <= 1'b1; i_req_type <= req; i_timer_index <= idx;
        i_delay_amount <= dly; i_handler_code <= hnd; i_user_argument <= arg;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        word_count++;
    endtask

    task automatic send_random();
        int pick;
        logic [15:0] dly;
        pick = $urandom_range(99);
        dly = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6));
        if (pick < 40)
            send(REQ_TICK, 4'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
        else if (pick < 65)
            send(REQ_SET_TICKS, 4'($urandom), dly, 8'($urandom), 16'($urandom));
        else if (pick < 72)
            send(REQ_SET_SEC, 4'($urandom), 16'($urandom_range(2)), 8'($urandom),
                 16'($urandom));
        else if (pick < 80)
            send(REQ_SET_MS, 4'($urandom), 16'($urandom_range(3000)), 8'($urandom),
                 16'($urandom));
        else if (pick < 87)
            send(REQ_RESET_SEC, 4'($urandom), 16'($urandom_range(1)), 8'($urandom),
                 16'($urandom));
        else if (pick < 97)
            send(REQ_CLEAR, 4'($urandom), dly, 8'($urandom), 16'($urandom));
        else
            send(3'($urandom_range(6, 7)), 4'($urandom), dly, 8'($urandom),
                 16'($urandom));
    endtask

    initial begin
        logic [9:0] scales[4] = '{10'd1, 10'd1000, 10'd0, 10'd1023};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: every request kind, extremes, ties, unknown codes
        send(REQ_TICK, 4'd0, 16'd0, 8'd0, 16'd0);
        send(REQ_CLEAR, 4'd3, 16'd0, 8'd0, 16'd0);
        send(REQ_RESET_SEC, 4'd3, 16'd1, 8'd0, 16'd0);
        send(REQ_SET_TICKS, 4'd15, 16'd1, 8'hFF, 16'hFFFF);
        send(REQ_SET_TICKS, 4'd0, 16'd1, 8'h00, 16'h0000);
        send(REQ_SET_TICKS, 4'd7, 16'd0, 8'h5A, 16'hA5A5);
        send(REQ_SET_SEC, 4'd1, 16'hFFFF, 8'h11, 16'h2222);
        send(REQ_SET_MS, 4'd2, 16'hFFFF, 8'h33, 16'h4444);
        send(REQ_SET_MS, 4'd4, 16'd50, 8'h55, 16'h6666);
        send(REQ_RESET_SEC, 4'd2, 16'd0, 8'd0, 16'd0);
        send(REQ_SET_TICKS, 4'd15, 16'd1, 8'hC3, 16'h3C3C);
        send(REQ_TICK, 4'd9, 16'd0, 8'd0, 16'd0);
        send(REQ_CLEAR, 4'd1, 16'd0, 8'd0, 16'd0);
        send(REQ_CLEAR, 4'd1, 16'd0, 8'd0, 16'd0);
        send(3'd6, 4'd5, 16'd9, 8'd1, 16'd1);
        send(3'd7, 4'd15, 16'hFFFF, 8'hFF, 16'hFFFF);
        // fill all sixteen with one expiry, fire them in one tick
        for (int i = 0; i < 16; i++)
            send(REQ_SET_TICKS, 4'(15 - i), 16'd1, 8'(i), 16'(i * 3));
        send(REQ_TICK, 4'd0, 16'd0, 8'd0, 16'd0);
        send(REQ_TICK, 4'd0, 16'd0, 8'd0, 16'd0);
        drain();

        // scale phases; long receiver hold-off in the first
        foreach (scales[s]) begin
            write_tps(scales[s]);
            if (s == 0) long_hold = 1'b1;
            for (int k = 0; k < 60; k++) send_random();
            drain();
        end
        write_tps(10'd18);
        calm = 1'b1;
        for (int k = 0; k < 50; k++) send_random();
        drain();

        $display("Sent %0d request words over 5 scales; %0d timers fired.",
                 word_count, fired_seen);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
